### hdl/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

    // field widths
    localparam int KEY_W       = 53;
    localparam int STAMP_W     = 52;
    localparam int DATA_W      = 32;
    localparam int TOPIC_W     = 2;
    localparam int PERIOD_W    = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // register file sizes
    localparam int MAX_SLOTS  = 3;
    localparam int MAX_TOPICS = 3;

    // parameter defaults
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int SLOT_COUNT_DEF  = 3;
    localparam int TOPIC_COUNT_DEF = 3;

    localparam logic OP_PUBLISH  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_QUEUED    = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_DELIVERED = 3'd2,
        STATUS_EMPTY     = 3'd3,
        STATUS_NO_MATCH  = 3'd4
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_EDF  = 2'd0,
        MODE_RM   = 2'd1,
        MODE_FIFO = 2'd2
    } sched_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCHED_MODE    = 3'd0,
        CFG_TOPIC0_PERIOD = 3'd1,
        CFG_TOPIC1_PERIOD = 3'd2,
        CFG_TOPIC2_PERIOD = 3'd3,
        CFG_SUB_COUNT     = 3'd4,
        CFG_SLOT0_TOPIC   = 3'd5,
        CFG_SLOT1_TOPIC   = 3'd6,
        CFG_SLOT2_TOPIC   = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // one queued message
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TOPIC_W-1:0] topic;
        logic [STAMP_W-1:0] stamp;
        logic [DATA_W-1:0]  data;
    } entry_t;

    // commands broadcast to the cell row
    typedef struct packed {
        logic insert;
        logic pop;
    } queue_cmd_t;

    // queue occupancy status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### hdl/dpd_cell.sv
`default_nettype none

module dpd_cell
(
    input  wire                 clk,
    input  dpd_pkg::queue_cmd_t cmd,
    input  dpd_pkg::entry_t     new_entry,
    input  dpd_pkg::entry_t     left_entry,
    input  dpd_pkg::entry_t     right_entry,
    input  wire                 left_gt,
    input  wire                 occupied,
    input  wire                 at_fill,
    output dpd_pkg::entry_t     entry,
    output logic                gt
);

    dpd_pkg::entry_t entry_reg;
    dpd_pkg::entry_t entry_next;

    // strictly larger key moves right, so equal keys stay oldest first
    assign gt    = occupied && (entry_reg.key > new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (gt || at_fill)
            begin
                entry_next = left_gt ? left_entry : new_entry;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### hdl/dpd_queue.sv
`default_nettype none

module dpd_queue
#(
    parameter int QUEUE_DEPTH = dpd_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  dpd_pkg::queue_cmd_t  cmd,
    input  dpd_pkg::entry_t      new_entry,
    output dpd_pkg::entry_t      head,
    output dpd_pkg::queue_stat_t stat
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    dpd_pkg::entry_t entries [QUEUE_DEPTH];
    logic            gts     [QUEUE_DEPTH];

    assign head       = entries[0];
    assign stat.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.insert)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // row of sorted cells, smallest key in cell 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        dpd_pkg::entry_t left_entry;
        dpd_pkg::entry_t right_entry;
        logic            left_gt;

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entries[i-1];
            assign left_gt    = gts[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_body
            assign right_entry = entries[i+1];
        end

        dpd_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .left_gt     (left_gt),
            .occupied    (FILL_W'(i) < fill_reg),
            .at_fill     (FILL_W'(i) == fill_reg),
            .entry       (entries[i]),
            .gt          (gts[i])
        );
    end

endmodule

`default_nettype wire

### hdl/deadline_priority_dispatcher.sv
// a queued, full or empty result shows in the cycle after the input beat is taken,
//   a dispatch first pops the head, then shows its delivered or no-match beats from ST_EMIT
// publish: key on accept, then sorted insert across the cell row in ST_INSERT; no insert if full
// dispatch: the pop, then one beat per matching slot or a single no-match beat; empty: one beat
// stalls hold result beats, an input beat is only taken in idle with the output register free
// reset (async, active low) empties the queue, clears all config registers and out_valid
`default_nettype none

module deadline_priority_dispatcher
#(
    parameter int QUEUE_DEPTH = dpd_pkg::QUEUE_DEPTH_DEF,
    parameter int SLOT_COUNT  = dpd_pkg::SLOT_COUNT_DEF,
    parameter int TOPIC_COUNT = dpd_pkg::TOPIC_COUNT_DEF
)
(
    input  wire                                clk,
    input  wire                                rst_n,

    // configuration write port
    input  wire                                cfg_we,
    input  wire  [dpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [dpd_pkg::CFG_DATA_W-1:0]     cfg_data,

    // input channel
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                operation,
    input  wire  [dpd_pkg::TOPIC_W-1:0]        topic,
    input  wire  [dpd_pkg::STAMP_W-1:0]        stamp_us,
    input  wire  [dpd_pkg::STAMP_W-1:0]        arrival_us,
    input  wire  [dpd_pkg::DATA_W-1:0]         payload,

    // output channel
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [dpd_pkg::STATUS_W-1:0]       status,
    output logic [dpd_pkg::SLOT_W-1:0]         slot,
    output logic [dpd_pkg::TOPIC_W-1:0]        out_topic,
    output logic [dpd_pkg::STAMP_W-1:0]        out_stamp,
    output logic [dpd_pkg::DATA_W-1:0]         out_payload,
    output logic [dpd_pkg::KEY_W-1:0]          out_key,
    output logic                               last
);

    // configuration registers
    logic [dpd_pkg::MODE_W-1:0]   sched_mode_reg;
    logic [dpd_pkg::PERIOD_W-1:0] period_reg     [dpd_pkg::MAX_TOPICS];
    logic [dpd_pkg::SLOT_W-1:0]   sub_count_reg;
    logic [dpd_pkg::TOPIC_W-1:0]  slot_topic_reg [dpd_pkg::MAX_SLOTS];

    // control state
    dpd_pkg::state_t state_reg;
    dpd_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [dpd_pkg::MAX_SLOTS-1:0] mask_reg;
    logic [dpd_pkg::MAX_SLOTS-1:0] mask_next;

    // payload registers: message in flight and the output beat
    dpd_pkg::entry_t             item_reg;
    dpd_pkg::entry_t             item_next;
    dpd_pkg::status_t            status_reg;
    dpd_pkg::status_t            status_next;
    logic [dpd_pkg::SLOT_W-1:0]  slot_reg;
    logic [dpd_pkg::SLOT_W-1:0]  slot_next;
    dpd_pkg::entry_t             out_msg_reg;
    dpd_pkg::entry_t             out_msg_next;
    logic                        last_reg;
    logic                        last_next;

    // queue interface
    dpd_pkg::queue_cmd_t  cmd;
    dpd_pkg::entry_t      head;
    dpd_pkg::queue_stat_t stat;

    logic                           out_free;
    logic                           in_accept;
    logic [dpd_pkg::PERIOD_W-1:0]   period;
    logic [dpd_pkg::KEY_W-1:0]      new_key;
    logic [dpd_pkg::SLOT_W-1:0]     pick;
    logic [dpd_pkg::MAX_SLOTS-1:0]  mask_rest;
    logic [dpd_pkg::MAX_SLOTS-1:0]  head_mask;

    // output register frees up when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == dpd_pkg::ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign out_topic   = out_msg_reg.topic;
    assign out_stamp   = out_msg_reg.stamp;
    assign out_payload = out_msg_reg.data;
    assign out_key     = out_msg_reg.key;
    assign last        = last_reg;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg <= '0;
            sub_count_reg  <= '0;
            for (int i = 0; i < dpd_pkg::MAX_TOPICS; i++)
            begin
                period_reg[i] <= '0;
            end
            for (int i = 0; i < dpd_pkg::MAX_SLOTS; i++)
            begin
                slot_topic_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (dpd_pkg::cfg_index_t'(cfg_index))
                dpd_pkg::CFG_SCHED_MODE:
                    sched_mode_reg <= cfg_data[dpd_pkg::MODE_W-1:0];
                dpd_pkg::CFG_TOPIC0_PERIOD:
                    period_reg[0] <= cfg_data[dpd_pkg::PERIOD_W-1:0];
                dpd_pkg::CFG_TOPIC1_PERIOD:
                    period_reg[1] <= cfg_data[dpd_pkg::PERIOD_W-1:0];
                dpd_pkg::CFG_TOPIC2_PERIOD:
                    period_reg[2] <= cfg_data[dpd_pkg::PERIOD_W-1:0];
                dpd_pkg::CFG_SUB_COUNT:
                    sub_count_reg <= cfg_data[dpd_pkg::SLOT_W-1:0];
                dpd_pkg::CFG_SLOT0_TOPIC:
                    slot_topic_reg[0] <= cfg_data[dpd_pkg::TOPIC_W-1:0];
                dpd_pkg::CFG_SLOT1_TOPIC:
                    slot_topic_reg[1] <= cfg_data[dpd_pkg::TOPIC_W-1:0];
                dpd_pkg::CFG_SLOT2_TOPIC:
                    slot_topic_reg[2] <= cfg_data[dpd_pkg::TOPIC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // key of a published message
    // ---------------------------------------------------------------
    always_comb
    begin
        // topics beyond the configured count have no period
        period = '0;
        if ((topic < dpd_pkg::TOPIC_W'(dpd_pkg::MAX_TOPICS))
            && (int'(topic) < TOPIC_COUNT))
        begin
            period = period_reg[topic];
        end
    end

    always_comb
    begin
        priority case (sched_mode_reg)
            dpd_pkg::MODE_EDF:
                new_key = dpd_pkg::KEY_W'(period) + dpd_pkg::KEY_W'(stamp_us);
            dpd_pkg::MODE_RM:
                new_key = dpd_pkg::KEY_W'(period);
            default:
                // arrival order, also for the unused mode code
                new_key = dpd_pkg::KEY_W'(arrival_us);
        endcase
    end

    // subscribers in use whose topic matches the head message
    always_comb
    begin
        for (int i = 0; i < dpd_pkg::MAX_SLOTS; i++)
        begin
            head_mask[i] = (dpd_pkg::SLOT_W'(i) < sub_count_reg) && (i < SLOT_COUNT)
                           && (slot_topic_reg[i] == head.topic);
        end
    end

    // lowest pending slot goes out first
    always_comb
    begin
        pick = '0;
        for (int i = dpd_pkg::MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = dpd_pkg::SLOT_W'(i);
            end
        end
        mask_rest       = mask_reg;
        mask_rest[pick] = 1'b0;
    end

    // ---------------------------------------------------------------
    // state machine: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == dpd_pkg::OP_PUBLISH)
                    begin
                        if (!stat.full)
                        begin
                            state_next = dpd_pkg::ST_INSERT;
                        end
                    end
                    else if (!stat.empty)
                    begin
                        state_next = dpd_pkg::ST_EMIT;
                    end
                end
            end
            dpd_pkg::ST_INSERT:
            begin
                state_next = dpd_pkg::ST_IDLE;
            end
            dpd_pkg::ST_EMIT:
            begin
                // no match, or the final matching slot, ends the dispatch
                if (out_free && (mask_rest == '0))
                begin
                    state_next = dpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpd_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // state machine: outputs and datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        cmd            = '0;
        item_next      = item_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_next      = slot_reg;
        out_msg_next   = out_msg_reg;
        last_next      = last_reg;

        unique case (state_reg)
            dpd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    // every single-beat answer carries zeros and last
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    out_msg_next   = '0;
                    last_next      = 1'b1;
                    if (operation == dpd_pkg::OP_PUBLISH)
                    begin
                        status_next = stat.full ? dpd_pkg::STATUS_FULL
                                                : dpd_pkg::STATUS_QUEUED;
                        item_next.key   = new_key;
                        item_next.topic = topic;
                        item_next.stamp = stamp_us;
                        item_next.data  = payload;
                    end
                    else if (stat.empty)
                    begin
                        status_next = dpd_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        // take the head, results follow from ST_EMIT
                        out_valid_next = 1'b0;
                        cmd.pop        = 1'b1;
                        item_next      = head;
                        mask_next      = head_mask;
                    end
                end
            end
            dpd_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            dpd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_msg_next   = item_reg;
                    last_next      = (mask_rest == '0);
                    mask_next      = mask_rest;
                    if (mask_reg == '0)
                    begin
                        status_next = dpd_pkg::STATUS_NO_MATCH;
                        slot_next   = '0;
                    end
                    else
                    begin
                        status_next = dpd_pkg::STATUS_DELIVERED;
                        slot_next   = pick;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        out_msg_reg <= out_msg_next;
        last_reg    <= last_next;
    end

    // ---------------------------------------------------------------
    // sorted cell row
    // ---------------------------------------------------------------
    dpd_queue
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_entry (item_reg),
        .head      (head),
        .stat      (stat)
    );

endmodule

`default_nettype wire
